// ----- src/pcra_pkg.sv -----
// ---------------------------------------------------------------------------
// PI current regulator package
// Register indexes, operation codes and the request word of the shared
// multiply-accumulate unit.
// ---------------------------------------------------------------------------
package pcra_pkg;

    localparam int REG_IDX_W = 3;
    localparam int OPND_W    = 32;
    localparam int MAC_W     = 64;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_BOUND   = 3'd5;

    localparam logic OP_REGULATE = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    typedef struct packed {
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic              hi_shift;
        logic [MAC_W-1:0]  addend;
    } mac_req_t;

endpackage

// ----- src/pcra_mac.sv -----
// ---------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Unsigned 32x32 product, optionally moved up one half word, plus a 64-bit
// addend; the sum wraps modulo 2^64.
// ---------------------------------------------------------------------------
module pcra_mac
(
    input  pcra_pkg::mac_req_t              req,
    output logic [pcra_pkg::MAC_W-1:0]      result
);
    import pcra_pkg::*;

    logic [MAC_W-1:0] prod;
    logic [MAC_W-1:0] shifted;

    assign prod    = MAC_W'(req.a) * MAC_W'(req.b);
    assign shifted = req.hi_shift ? {prod[OPND_W-1:0], {OPND_W{1'b0}}} : prod;
    assign result  = shifted + req.addend;

endmodule

// ----- src/pi_current_regulator_antiwindup_core.sv -----
// ---------------------------------------------------------------------------
// PI current regulator with conditional-integration anti-windup
// A regulate word is accepted in ST_IDLE and then takes four passes through
// the one shared 32x32 multiply-accumulate unit (gain times period, two
// partial products of the increment, proportional term), then the integral
// add and limit, the output sum and the clamp and decision, in that order.
// A clear word, or a regulate word while the sample period is zero, goes
// from ST_IDLE straight to its result state. Input is stalled while a word
// is in progress, and a held-off output register stretches the last step; a
// finished result waits in the output register while the next word enters.
// ---------------------------------------------------------------------------
module pi_current_regulator_antiwindup_core
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                wr_en,
    input  logic [pcra_pkg::REG_IDX_W-1:0]                      wr_index,
    input  logic [((DATA_WIDTH > 24) ? DATA_WIDTH : 24)-1:0]    wr_data,
    input  logic                                                in_valid,
    output logic                                                in_stall,
    input  logic                                                op,
    input  logic signed [DATA_WIDTH-1:0]                        err_sample,
    output logic                                                out_valid,
    input  logic                                                out_stall,
    output logic signed [DATA_WIDTH-1:0]                        drive,
    output logic                                                sat_flag,
    output logic [31:0]                                         sat_events
);
    import pcra_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HOLD,
        ST_MUL_GP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_PROP,
        ST_CAND,
        ST_RAW,
        ST_DECIDE
    } state_t;

    state_t                      state_reg, state_next;

    logic [15:0]                 pg_reg, pg_next;
    logic [23:0]                 ig_reg, ig_next;
    logic [23:0]                 sp_reg, sp_next;
    logic signed [DATA_WIDTH-1:0] dmin_reg, dmin_next;
    logic signed [DATA_WIDTH-1:0] dmax_reg, dmax_next;
    logic [14:0]                 bound_reg, bound_next;

    logic signed [31:0]          acc_reg, acc_next;
    logic                        sat_reg, sat_next;
    logic [31:0]                 cnt_reg, cnt_next;

    logic [DATA_WIDTH-1:0]       mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic                        pos_reg, pos_next;
    logic [47:0]                 gp_reg, gp_next;
    logic [MAC_W-1:0]            prod_reg, prod_next;
    logic [47:0]                 prop_reg, prop_next;
    logic signed [MAC_W-1:0]     cand_reg, cand_next;
    logic signed [MAC_W-1:0]     raw_reg, raw_next;

    logic                        out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] drive_reg, drive_next;
    logic                        sat_flag_reg, sat_flag_next;
    logic [31:0]                 sat_events_reg, sat_events_next;

    mac_req_t                    mac_req;
    logic [MAC_W-1:0]            mac_res;

    logic signed [MAC_W-1:0]     lo_q, hi_q, bnd_q, acc_ext;
    logic signed [MAC_W-1:0]     inc_mag, inc_s, sum_s, cand_clamp;
    logic signed [MAC_W-1:0]     prop_mag, prop_s, raw_sum;
    logic signed [MAC_W-1:0]     hold_clamp, raw_clamp;
    logic                        raw_sat, out_room;
    logic [DATA_WIDTH-1:0]       err_mag;

    function automatic logic signed [MAC_W-1:0] clamp_q(
        input logic signed [MAC_W-1:0] x,
        input logic signed [MAC_W-1:0] lo,
        input logic signed [MAC_W-1:0] hi
    );
        logic signed [MAC_W-1:0] r;
        if (x < lo)
        begin
            r = lo;
        end
        else if (x > hi)
        begin
            r = hi;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    pcra_mac u_mac
    (
        .req    (mac_req),
        .result (mac_res)
    );

    assign lo_q       = MAC_W'(dmin_reg) <<< 16;
    assign hi_q       = MAC_W'(dmax_reg) <<< 16;
    assign bnd_q      = $signed(MAC_W'({bound_reg, 16'h0000}));
    assign acc_ext    = MAC_W'(acc_reg);
    assign inc_mag    = $signed(MAC_W'(prod_reg[MAC_W-1:16]));
    assign inc_s      = neg_reg ? -inc_mag : inc_mag;
    assign sum_s      = acc_ext + inc_s;
    assign cand_clamp = clamp_q(sum_s, -bnd_q, bnd_q);
    assign prop_mag   = $signed(MAC_W'({prop_reg, 8'h00}));
    assign prop_s     = neg_reg ? -prop_mag : prop_mag;
    assign raw_sum    = prop_s + cand_reg;
    assign hold_clamp = clamp_q(acc_ext, lo_q, hi_q);
    assign raw_clamp  = clamp_q(raw_reg, lo_q, hi_q);
    assign raw_sat    = ((raw_reg > hi_q) && pos_reg) || ((raw_reg < lo_q) && neg_reg);
    assign out_room   = !out_valid_reg || !out_stall;
    assign err_mag    = err_sample[DATA_WIDTH-1] ? -err_sample : err_sample;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign drive      = drive_reg;
    assign sat_flag   = sat_flag_reg;
    assign sat_events = sat_events_reg;

    always_comb
    begin
        mac_req         = '0;
        state_next      = state_reg;
        pg_next         = pg_reg;
        ig_next         = ig_reg;
        sp_next         = sp_reg;
        dmin_next       = dmin_reg;
        dmax_next       = dmax_reg;
        bound_next      = bound_reg;
        acc_next        = acc_reg;
        sat_next        = sat_reg;
        cnt_next        = cnt_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        gp_next         = gp_reg;
        prod_next       = prod_reg;
        prop_next       = prop_reg;
        cand_next       = cand_reg;
        raw_next        = raw_reg;
        out_valid_next  = out_valid_reg && out_stall;
        drive_next      = drive_reg;
        sat_flag_next   = sat_flag_reg;
        sat_events_next = sat_events_reg;

        if (wr_en)
        begin
            case (wr_index)
                REG_PROP_GAIN:     pg_next    = wr_data[15:0];
                REG_INTEG_GAIN:    ig_next    = wr_data[23:0];
                REG_SAMPLE_PERIOD: sp_next    = wr_data[23:0];
                REG_DRIVE_MIN:     dmin_next  = $signed(wr_data[DATA_WIDTH-1:0]);
                REG_DRIVE_MAX:     dmax_next  = $signed(wr_data[DATA_WIDTH-1:0]);
                REG_INTEG_BOUND:   bound_next = wr_data[14:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next = err_mag;
                    neg_next = err_sample[DATA_WIDTH-1];
                    pos_next = !err_sample[DATA_WIDTH-1] && (err_sample != '0);
                    if (op == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (sp_reg == '0)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_MUL_GP;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (out_room)
                begin
                    acc_next        = '0;
                    sat_next        = 1'b0;
                    cnt_next        = '0;
                    out_valid_next  = 1'b1;
                    drive_next      = '0;
                    sat_flag_next   = 1'b0;
                    sat_events_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_HOLD:
            begin
                if (out_room)
                begin
                    out_valid_next  = 1'b1;
                    drive_next      = hold_clamp[DATA_WIDTH+15:16];
                    sat_flag_next   = sat_reg;
                    sat_events_next = cnt_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_MUL_GP:
            begin
                mac_req.a  = OPND_W'(ig_reg);
                mac_req.b  = OPND_W'(sp_reg);
                gp_next    = mac_res[47:0];
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                mac_req.a  = gp_reg[31:0];
                mac_req.b  = OPND_W'(mag_reg);
                prod_next  = mac_res;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                mac_req.a        = OPND_W'(gp_reg[47:32]);
                mac_req.b        = OPND_W'(mag_reg);
                mac_req.hi_shift = 1'b1;
                mac_req.addend   = prod_reg;
                prod_next        = mac_res;
                state_next       = ST_MUL_PROP;
            end
            ST_MUL_PROP:
            begin
                mac_req.a  = OPND_W'(pg_reg);
                mac_req.b  = OPND_W'(mag_reg);
                prop_next  = mac_res[47:0];
                state_next = ST_CAND;
            end
            ST_CAND:
            begin
                cand_next  = cand_clamp;
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                raw_next   = raw_sum;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_room)
                begin
                    if (raw_sat)
                    begin
                        sat_next        = 1'b1;
                        cnt_next        = cnt_reg + 32'd1;
                        sat_events_next = cnt_reg + 32'd1;
                    end
                    else
                    begin
                        acc_next        = cand_reg[31:0];
                        sat_next        = 1'b0;
                        sat_events_next = cnt_reg;
                    end
                    sat_flag_next  = raw_sat;
                    out_valid_next = 1'b1;
                    drive_next     = raw_clamp[DATA_WIDTH+15:16];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pg_reg         <= 16'd256;
            ig_reg         <= '0;
            sp_reg         <= '0;
            dmin_reg       <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            dmax_reg       <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            bound_reg      <= 15'h7FFF;
            acc_reg        <= '0;
            sat_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pg_reg         <= pg_next;
            ig_reg         <= ig_next;
            sp_reg         <= sp_next;
            dmin_reg       <= dmin_next;
            dmax_reg       <= dmax_next;
            bound_reg      <= bound_next;
            acc_reg        <= acc_next;
            sat_reg        <= sat_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        pos_reg        <= pos_next;
        gp_reg         <= gp_next;
        prod_reg       <= prod_next;
        prop_reg       <= prop_next;
        cand_reg       <= cand_next;
        raw_reg        <= raw_next;
        drive_reg      <= drive_next;
        sat_flag_reg   <= sat_flag_next;
        sat_events_reg <= sat_events_next;
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// PI current regulator testbench
// Drives error words through the regulator under a series of gain, period,
// clamp and integral-limit settings. A scoreboard predicts each drive word,
// the saturation flag and the saturation count, and checks them in order.
// Both sides of the word handshake idle at random, then one side holds off.
// ---------------------------------------------------------------------------
module tb;
    import pcra_pkg::*;

    localparam int DW   = 16;
    localparam int WR_W = (DW > 24) ? DW : 24;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic signed [DW-1:0] ERR_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ERR_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 flag;
        logic [31:0]          events;
    } drive_word_t;

    class drive_tracker;
        logic [15:0]          kp;
        logic [23:0]          ki;
        logic [23:0]          period;
        logic signed [DW-1:0] lo_lim;
        logic signed [DW-1:0] hi_lim;
        logic [14:0]          bound;
        logic signed [31:0]   integ;
        logic                 sat;
        logic [31:0]          sat_tally;
        drive_word_t          expected_drives[$];
        int                   errors;
        int                   results;
        int                   saturated;

        function new();
            kp        = 16'd256;
            ki        = '0;
            period    = '0;
            lo_lim    = ERR_MIN;
            hi_lim    = ERR_MAX;
            bound     = 15'h7fff;
            integ     = '0;
            sat       = 1'b0;
            sat_tally = '0;
            errors    = 0;
            results   = 0;
            saturated = 0;
        endfunction

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [WR_W-1:0] value);
            case (idx)
                REG_PROP_GAIN:     kp     = value[15:0];
                REG_INTEG_GAIN:    ki     = value[23:0];
                REG_SAMPLE_PERIOD: period = value[23:0];
                REG_DRIVE_MIN:     lo_lim = value[DW-1:0];
                REG_DRIVE_MAX:     hi_lim = value[DW-1:0];
                REG_INTEG_BOUND:   bound  = value[14:0];
                default: ;
            endcase
        endfunction

        function longint clamp_q16(input longint x, input longint lo, input longint hi);
            if (x < lo)
                return lo;
            if (x > hi)
                return hi;
            return x;
        endfunction

        function void note_word(input logic o, input logic signed [DW-1:0] e);
            longint          lo, hi, acc, err, inc, bnd, cand, raw, kpl, q;
            longint unsigned mag, gain;
            drive_word_t     w;
            lo  = lo_lim;
            lo  = lo * 65536;
            hi  = hi_lim;
            hi  = hi * 65536;
            acc = integ;
            if (o == OP_CLEAR)
            begin
                integ     = '0;
                sat       = 1'b0;
                sat_tally = '0;
                w         = '0;
            end
            else
            begin
                err = e;
                if (period == 0)
                begin
                    q = clamp_q16(acc, lo, hi) >>> 16;
                end
                else
                begin
                    mag  = (err < 0) ? -err : err;
                    gain = ki;
                    gain = gain * period;
                    mag  = (gain * mag) >> 16;
                    inc  = mag;
                    if (err < 0)
                        inc = -inc;
                    bnd  = bound;
                    bnd  = bnd * 65536;
                    cand = clamp_q16(acc + inc, -bnd, bnd);
                    kpl  = kp;
                    raw  = kpl * err * 256 + cand;
                    if ((raw > hi && err > 0) || (raw < lo && err < 0))
                    begin
                        sat       = 1'b1;
                        sat_tally = sat_tally + 32'd1;
                    end
                    else
                    begin
                        integ = cand[31:0];
                        sat   = 1'b0;
                    end
                    q = clamp_q16(raw, lo, hi) >>> 16;
                end
                w.drive  = q[DW-1:0];
                w.flag   = sat;
                w.events = sat_tally;
            end
            expected_drives.push_back(w);
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 100)
                $display("%0t mismatch: %s", $time, what);
        endtask

        task check_word(input logic signed [DW-1:0] d, input logic f, input logic [31:0] ev);
            drive_word_t w;
            results++;
            if (f === 1'b1)
                saturated++;
            if (expected_drives.size() == 0)
            begin
                report($sformatf("result with nothing pending, drive %0d", d));
                return;
            end
            w = expected_drives.pop_front();
            if (d !== w.drive)
                report($sformatf("drive %0d, predicted %0d", d, w.drive));
            if (f !== w.flag)
                report($sformatf("sat_flag %b, predicted %b", f, w.flag));
            if (ev !== w.events)
                report($sformatf("sat_events %0d, predicted %0d", ev, w.events));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [WR_W-1:0]      wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 op;
    logic signed [DW-1:0] err_sample;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [DW-1:0] drive;
    logic                 sat_flag;
    logic [31:0]          sat_events;

    drive_tracker tracker;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int words_taken;
    int clears_taken;
    int settings_used;

    pi_current_regulator_antiwindup_core #(.DATA_WIDTH(DW)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .err_sample (err_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive),
        .sat_flag   (sat_flag),
        .sat_events (sat_events)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            tracker.note_word(op, err_sample);
            words_taken++;
            if (op == OP_CLEAR)
                clears_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_word(drive, sat_flag, sat_events);
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    initial
    begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

    task automatic drain(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_drives.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WR_W-1:0] value);
        drain(12);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en    <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic send_word(input logic o, input logic signed [DW-1:0] e);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= o;
        err_sample <= e;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [31:0] scaled(input int bits);
        int k;
        k = $urandom_range(bits, 0);
        if ($urandom_range(9, 0) == 0)
            return (32'h1 << bits) - 1;
        return $urandom & ((32'h1 << k) - 1);
    endfunction

    function automatic logic signed [DW-1:0] pick_error();
        logic signed [DW-1:0] e;
        int                   sel;
        sel = $urandom_range(99, 0);
        if (sel < 15)
        begin
            case ($urandom_range(4, 0))
                0:       e = ERR_MIN;
                1:       e = ERR_MAX;
                2:       e = 0;
                3:       e = 1;
                default: e = -1;
            endcase
        end
        else if (sel < 40)
            e = DW'($urandom);
        else
        begin
            e = DW'(scaled(DW - 1));
            if ($urandom_range(1, 0))
                e = -e;
        end
        return e;
    endfunction

    task automatic random_setting();
        logic [23:0]          kp, ki, per, bnd;
        logic signed [DW-1:0] a, b, t;
        int                   sel;
        kp  = 24'(scaled(16));
        ki  = 24'(scaled(24));
        per = ($urandom_range(99, 0) < 12) ? 24'd0 : 24'(scaled(24));
        bnd = 24'(scaled(15));
        a   = pick_error();
        b   = pick_error();
        sel = $urandom_range(99, 0);
        if (sel < 10)
        begin
            a = ERR_MIN;
            b = ERR_MAX;
        end
        else if ((sel < 20) == (a < b))
        begin
            t = a;
            a = b;
            b = t;
        end
        write_reg(REG_PROP_GAIN,     {8'($urandom), kp[15:0]});
        write_reg(REG_INTEG_GAIN,    ki);
        write_reg(REG_SAMPLE_PERIOD, per);
        write_reg(REG_DRIVE_MIN,     {8'($urandom), a});
        write_reg(REG_DRIVE_MAX,     {8'($urandom), b});
        write_reg(REG_INTEG_BOUND,   {9'($urandom), bnd[14:0]});
        if ($urandom_range(3, 0) == 0)
            write_reg($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, WR_W'($urandom));
        settings_used++;
    endtask

    // runs of similar error wind the integral up against the clamps
    task automatic random_words(input int count);
        int                   n, run;
        logic signed [DW-1:0] base;
        longint               t;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(24, 0) == 0)
            begin
                send_word(OP_CLEAR, DW'($urandom));
                n++;
            end
            else
            begin
                run  = $urandom_range(20, 1);
                base = pick_error();
                repeat (run)
                begin
                    t = base + int'($urandom_range(30, 0)) - 15;
                    if (t > ERR_MAX)
                        t = ERR_MAX;
                    if (t < ERR_MIN)
                        t = ERR_MIN;
                    send_word(OP_REGULATE, t[DW-1:0]);
                    n++;
                end
            end
        end
    endtask

    task automatic directed_words();
        send_word(OP_REGULATE, ERR_MAX);
        send_word(OP_REGULATE, ERR_MIN);
        send_word(OP_CLEAR, 16'h1234);

        write_reg(REG_PROP_GAIN,     24'd256);
        write_reg(REG_INTEG_GAIN,    24'd256000);
        write_reg(REG_SAMPLE_PERIOD, 24'd839);
        write_reg(REG_DRIVE_MIN,     {8'h00, 16'(-1000)});
        write_reg(REG_DRIVE_MAX,     24'd1000);
        write_reg(REG_INTEG_BOUND,   24'd500);
        send_word(OP_REGULATE, ERR_MAX);
        send_word(OP_REGULATE, ERR_MIN);
        send_word(OP_REGULATE, 0);
        send_word(OP_REGULATE, 1);
        send_word(OP_REGULATE, -1);
        repeat (3) send_word(OP_REGULATE, 300);
        // hold: zero period reports the clamped integral
        write_reg(REG_SAMPLE_PERIOD, 24'd0);
        send_word(OP_REGULATE, 300);
        send_word(OP_CLEAR, 0);

        // crossed clamps
        write_reg(REG_SAMPLE_PERIOD, 24'd839);
        write_reg(REG_DRIVE_MIN,     24'd100);
        write_reg(REG_DRIVE_MAX,     {8'hff, 16'(-100)});
        send_word(OP_REGULATE, 0);
        send_word(OP_REGULATE, 50);
        send_word(OP_REGULATE, -50);
        send_word(OP_REGULATE, 200);
        send_word(OP_REGULATE, -200);

        write_reg(REG_PROP_GAIN,     24'hffffff);
        write_reg(REG_INTEG_GAIN,    24'hffffff);
        write_reg(REG_SAMPLE_PERIOD, 24'hffffff);
        write_reg(REG_DRIVE_MIN,     {8'h00, ERR_MIN});
        write_reg(REG_DRIVE_MAX,     {8'h00, ERR_MAX});
        write_reg(REG_SPARE_LO,      24'hffffff);
        write_reg(REG_SPARE_HI,      24'h5a5a5a);
        send_word(OP_REGULATE, ERR_MAX);
        send_word(OP_REGULATE, ERR_MIN);
        send_word(OP_REGULATE, 1);
        send_word(OP_REGULATE, -1);

        write_reg(REG_INTEG_BOUND, 24'd0);
        send_word(OP_REGULATE, 1000);
        settings_used += 5;
    endtask

    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        in_valid      = 1'b0;
        op            = OP_REGULATE;
        err_sample    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 0;
        hold_seq      = 0;
        words_taken   = 0;
        clears_taken  = 0;
        settings_used = 1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        directed_words();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 21 : 0;
            for (int seg = 0; seg < 10; seg++)
            begin
                random_setting();
                random_words(57);
            end
        end

        // hold the receiver off while words keep coming, then pause until empty
        drain(12);
        hold_len = 300;
        hold_seq++;
        random_words(40);
        drain(20);

        $display("summary: %0d words accepted (%0d clears) over %0d register settings",
                 words_taken, clears_taken, settings_used);
        $display("summary: %0d results checked, %0d with saturation, %0d cycle hold-off",
                 tracker.results, tracker.saturated, hold_len);
        if (tracker.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
